// ----- rtl/core/joint_histogram_bin_accumulate_assert.svh -----
// Assertion macros for the joint histogram block.
// Each use names a label and a property expression; clk and rst come from
// the module that uses the macro.
`ifndef JOINT_HISTOGRAM_BIN_ACCUMULATE_ASSERT_SVH
`define JOINT_HISTOGRAM_BIN_ACCUMULATE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define JHBA_ASSERT(lbl, prop) lbl: assert property (@(posedge clk) disable iff (rst) prop) \
  else $error("jhba assertion failed");
`define JHBA_ASSERT_RST(lbl, prop) lbl: assert property (@(posedge clk) prop) \
  else $error("jhba assertion failed during or after reset");
`else
`define JHBA_ASSERT(lbl, prop)
`define JHBA_ASSERT_RST(lbl, prop)
`endif
`endif

// ----- rtl/core/jhba_pkg.sv -----
// ----------------------------------------------------------------------------
// jhba_pkg
// Shared constants, codes and controller/datapath types of the joint
// histogram block.
// ----------------------------------------------------------------------------
package jhba_pkg;

  localparam int MAX_BINS    = 64;
  localparam int NUM_AXES    = 2;
  localparam int EDGE_ROW    = MAX_BINS + 1;
  localparam int EDGE_DEPTH  = NUM_AXES * EDGE_ROW;
  localparam int STORE_DEPTH = (MAX_BINS + 2) * (MAX_BINS + 2);
  localparam int EDGE_AW     = $clog2(EDGE_DEPTH);
  localparam int CNT_AW      = 13;
  localparam int BIN_W       = 7;
  localparam int CNT_W       = 48;
  localparam int VAL_W       = 32;
  localparam int CFG_IW      = 3;
  localparam int CFG_DW      = 7;

  // register indexes
  localparam logic [CFG_IW-1:0] CFG_BINS_A  = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_BINS_B  = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_INCMAX_A = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_INCMAX_B = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_WEIGHTED = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_AXES    = 3'd5;

  // item modes
  localparam logic [1:0] MODE_LOAD   = 2'd0;
  localparam logic [1:0] MODE_SAMPLE = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam logic signed [CNT_W-1:0] ONE_Q16 = 48'sd65536;
  localparam logic signed [CNT_W-1:0] CNT_MAX = {1'b0, {(CNT_W-1){1'b1}}};
  localparam logic signed [CNT_W-1:0] CNT_MIN = {1'b1, {(CNT_W-1){1'b0}}};

  // controller to datapath commands
  typedef struct packed {
    logic latch;
    logic axis_first;
    logic axis_next;
    logic rd_first;
    logic rd_last;
    logic cap_first;
    logic chk;
    logic rd_mid;
    logic step;
    logic fin_search;
    logic mk_flat;
    logic cnt_rd;
    logic cnt_out;
    logic rd_rd;
    logic rd_out;
    logic ld_out;
    logic clr_step;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [1:0] mode;
    logic       nax2;
    logic       axis;
    logic       early;
    logic       narrow;
    logic       out_free;
    logic       clr_last;
  } status_t;

endpackage

// ----- rtl/core/jhba_in_if.sv -----
// ----------------------------------------------------------------------------
// jhba_in_if
// Input word channel: valid/ready handshake with the sample payload.
// ----------------------------------------------------------------------------
interface jhba_in_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        mode;
  logic                              axis;
  logic [12:0]                       slot;
  logic signed [jhba_pkg::VAL_W-1:0] value_a;
  logic signed [jhba_pkg::VAL_W-1:0] value_b;
  logic                              masked_a;
  logic                              masked_b;
  logic signed [jhba_pkg::VAL_W-1:0] weight;
  logic                              weight_masked;

  modport source (output valid, mode, axis, slot, value_a, value_b, masked_a, masked_b,
                  weight, weight_masked, input ready);
  modport sink (input valid, mode, axis, slot, value_a, value_b, masked_a, masked_b,
                weight, weight_masked, output ready);
endinterface

// ----- rtl/core/jhba_out_if.sv -----
// ----------------------------------------------------------------------------
// jhba_out_if
// Result word channel: valid/ready handshake with the result payload.
// ----------------------------------------------------------------------------
interface jhba_out_if;
  logic                              valid;
  logic                              ready;
  logic [jhba_pkg::BIN_W-1:0]        bin_a;
  logic [jhba_pkg::BIN_W-1:0]        bin_b;
  logic                              counted;
  logic [jhba_pkg::CNT_AW-1:0]       flat_index;
  logic signed [jhba_pkg::CNT_W-1:0] count_value;

  modport source (output valid, bin_a, bin_b, counted, flat_index, count_value,
                  input ready);
  modport sink (input valid, bin_a, bin_b, counted, flat_index, count_value,
                output ready);
endinterface

// ----- rtl/core/joint_histogram_bin_accumulate.sv -----
// ----------------------------------------------------------------------------
// joint_histogram_bin_accumulate
// Joint one- or two-axis histogram with loaded Q16.16 bin edges and a
// saturating Q32.16 count store.
// ----------------------------------------------------------------------------
// Usage:
//   samples carries one input word per item: mode 0 loads an edge, mode 1
//   bins a sample and adds 1.0 or its weight, mode 2 reads one count.
//   results returns exactly one word per accepted input word.
//   cfg_we/cfg_index/cfg_data write the six setup registers; write only while
//   the block is idle.
// Operation:
//   Each axis in use is binned from its first and last edge reads; a value
//   below the first edge or at or above the last is settled there, else a
//   binary search follows, one edge RAM read per step (6 steps for 64 bins).
//   One item is worked on at a time; the next is taken once a result is
//   registered, even while that result waits on results.ready.
// Reset:
//   The count store is cleared by a pass over all 4356 words, one word a cycle;
//   samples.ready stays low until it ends. Edges are undefined until loaded.
// Stall:
//   A stalled result holds; the following item waits at its final step.
module joint_histogram_bin_accumulate (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [jhba_pkg::CFG_IW-1:0] cfg_index,
  input  logic [jhba_pkg::CFG_DW-1:0] cfg_data,
  jhba_in_if.sink                     samples,
  jhba_out_if.source                  results
);

  jhba_pkg::cmd_t    cmd;
  jhba_pkg::status_t st;

  jhba_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(samples.valid), .in_ready(samples.ready),
    .st(st), .cmd(cmd)
  );

  jhba_dp u_dp (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_mode(samples.mode), .in_axis(samples.axis), .in_slot(samples.slot),
    .in_value_a(samples.value_a), .in_value_b(samples.value_b),
    .in_masked_a(samples.masked_a), .in_masked_b(samples.masked_b),
    .in_weight(samples.weight), .in_weight_masked(samples.weight_masked),
    .cmd(cmd), .st(st),
    .out_valid(results.valid), .out_ready(results.ready),
    .out_bin_a(results.bin_a), .out_bin_b(results.bin_b),
    .out_counted(results.counted), .out_flat_index(results.flat_index),
    .out_count_value(results.count_value)
  );

endmodule

// ----- rtl/core/jhba_ram.sv -----
// ----------------------------------------------------------------------------
// jhba_ram
// Generic single-write, single-read RAM with registered, enabled read.
// ----------------------------------------------------------------------------
module jhba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/jhba_ctrl.sv -----
// ----------------------------------------------------------------------------
// jhba_ctrl
// Sequencer: clearing pass, edge search steps per axis, count update,
// read and load handling.
// ----------------------------------------------------------------------------
module jhba_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  jhba_pkg::status_t st,
  output jhba_pkg::cmd_t    cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CLR  = 4'd1;
  localparam logic [3:0] S_DEC  = 4'd2;
  localparam logic [3:0] S_RD0  = 4'd3;
  localparam logic [3:0] S_RDN  = 4'd4;
  localparam logic [3:0] S_CHK  = 4'd5;
  localparam logic [3:0] S_MID  = 4'd6;
  localparam logic [3:0] S_CMP  = 4'd7;
  localparam logic [3:0] S_FLAT = 4'd8;
  localparam logic [3:0] S_CRD  = 4'd9;
  localparam logic [3:0] S_CWR  = 4'd10;
  localparam logic [3:0] S_RRD  = 4'd11;
  localparam logic [3:0] S_ROUT = 4'd12;
  localparam logic [3:0] S_LOUT = 4'd13;

  logic [3:0] state;
  logic [3:0] state_next;
  logic [3:0] axis_done_next;

  assign in_ready = (state == S_IDLE);

  // after an axis is binned: second axis or flat index
  always_comb begin
    if (!st.axis && st.nax2) begin
      axis_done_next = S_RD0;
    end else begin
      axis_done_next = S_FLAT;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (st.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        if (st.mode == jhba_pkg::MODE_SAMPLE) begin
          cmd.axis_first = 1'b1;
          state_next = S_RD0;
        end else if (st.mode == jhba_pkg::MODE_READ) begin
          state_next = S_RRD;
        end else begin
          state_next = S_LOUT;
        end
      end
      S_RD0: begin
        cmd.rd_first = 1'b1;
        state_next = S_RDN;
      end
      S_RDN: begin
        cmd.rd_last = 1'b1;
        cmd.cap_first = 1'b1;
        state_next = S_CHK;
      end
      S_CHK: begin
        cmd.chk = 1'b1;
        if (st.early) begin
          cmd.axis_next = (axis_done_next == S_RD0);
          state_next = axis_done_next;
        end else begin
          state_next = S_MID;
        end
      end
      S_MID: begin
        if (st.narrow) begin
          cmd.fin_search = 1'b1;
          cmd.axis_next = (axis_done_next == S_RD0);
          state_next = axis_done_next;
        end else begin
          cmd.rd_mid = 1'b1;
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        cmd.step = 1'b1;
        state_next = S_MID;
      end
      S_FLAT: begin
        cmd.mk_flat = 1'b1;
        state_next = S_CRD;
      end
      S_CRD: begin
        cmd.cnt_rd = 1'b1;
        state_next = S_CWR;
      end
      S_CWR: begin
        if (st.out_free) begin
          cmd.cnt_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_RRD: begin
        cmd.rd_rd = 1'b1;
        state_next = S_ROUT;
      end
      S_ROUT: begin
        if (st.out_free) begin
          cmd.rd_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_LOUT: begin
        if (st.out_free) begin
          cmd.ld_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register, reset starts the clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- rtl/core/jhba_dp.sv -----
// ----------------------------------------------------------------------------
// jhba_dp
// Datapath: configuration registers, edge table, binary search registers,
// flat index, count store with saturating add, and the result register.
// ----------------------------------------------------------------------------
`include "joint_histogram_bin_accumulate_assert.svh"

module jhba_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [jhba_pkg::CFG_IW-1:0]         cfg_index,
  input  logic [jhba_pkg::CFG_DW-1:0]         cfg_data,
  input  logic [1:0]                          in_mode,
  input  logic                                in_axis,
  input  logic [12:0]                         in_slot,
  input  logic signed [jhba_pkg::VAL_W-1:0]   in_value_a,
  input  logic signed [jhba_pkg::VAL_W-1:0]   in_value_b,
  input  logic                                in_masked_a,
  input  logic                                in_masked_b,
  input  logic signed [jhba_pkg::VAL_W-1:0]   in_weight,
  input  logic                                in_weight_masked,
  input  jhba_pkg::cmd_t                      cmd,
  output jhba_pkg::status_t                   st,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [jhba_pkg::BIN_W-1:0]          out_bin_a,
  output logic [jhba_pkg::BIN_W-1:0]          out_bin_b,
  output logic                                out_counted,
  output logic [jhba_pkg::CNT_AW-1:0]         out_flat_index,
  output logic signed [jhba_pkg::CNT_W-1:0]   out_count_value
);

  localparam int BW = jhba_pkg::BIN_W;
  localparam int AW = jhba_pkg::CNT_AW;
  localparam int EW = jhba_pkg::EDGE_AW;
  localparam int CW = jhba_pkg::CNT_W;
  localparam int VW = jhba_pkg::VAL_W;

  // configuration
  logic [BW-1:0] bins_a, bins_b;
  logic          include_max_a, include_max_b, weighted;
  logic [1:0]    axes_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      bins_a <= BW'(1);
      bins_b <= BW'(1);
      include_max_a <= 1'b0;
      include_max_b <= 1'b0;
      weighted <= 1'b0;
      axes_in_use <= 2'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        jhba_pkg::CFG_BINS_A:   bins_a <= cfg_data;
        jhba_pkg::CFG_BINS_B:   bins_b <= cfg_data;
        jhba_pkg::CFG_INCMAX_A: include_max_a <= cfg_data[0];
        jhba_pkg::CFG_INCMAX_B: include_max_b <= cfg_data[0];
        jhba_pkg::CFG_WEIGHTED: weighted <= cfg_data[0];
        jhba_pkg::CFG_AXES:     axes_in_use <= cfg_data[1:0];
        default: begin
        end
      endcase
    end
  end

  // effective bin counts, clamped to 1..MAX_BINS
  logic [BW-1:0] na, nb;
  logic          nax2;
  assign na = (bins_a == '0) ? BW'(1) :
              (bins_a > BW'(jhba_pkg::MAX_BINS)) ? BW'(jhba_pkg::MAX_BINS) : bins_a;
  assign nb = (bins_b == '0) ? BW'(1) :
              (bins_b > BW'(jhba_pkg::MAX_BINS)) ? BW'(jhba_pkg::MAX_BINS) : bins_b;
  assign nax2 = (axes_in_use >= 2'd2) && (jhba_pkg::NUM_AXES >= 2);

  // latched input word
  logic [1:0]          mode;
  logic                axis_in;
  logic [12:0]         slot;
  logic signed [VW-1:0] va, vb, w;
  logic                ma, mb, mw;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      mode <= in_mode;
      axis_in <= in_axis;
      slot <= in_slot;
      va <= in_value_a;
      vb <= in_value_b;
      ma <= in_masked_a;
      mb <= in_masked_b;
      w <= in_weight;
      mw <= in_weight_masked;
    end
  end

  // current axis selection
  logic                 axis;
  logic signed [VW-1:0] v_cur;
  logic [BW-1:0]        n_cur;
  logic                 incmax_cur;
  logic [EW-1:0]        base;
  assign v_cur = axis ? vb : va;
  assign n_cur = axis ? nb : na;
  assign incmax_cur = axis ? include_max_b : include_max_a;
  assign base = axis ? EW'(jhba_pkg::EDGE_ROW) : '0;

  // edge table
  logic [BW-1:0]        lo, hi;
  logic [BW:0]          mid_sum;
  logic [BW-1:0]        mid;
  logic [EW-1:0]        e_raddr, e_waddr;
  logic [VW-1:0]        e_rdata;
  logic signed [VW-1:0] e_val;
  logic                 e_we, e_re;

  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign mid = mid_sum[BW:1];
  assign e_val = e_rdata;
  assign e_re = cmd.rd_first | cmd.rd_last | cmd.rd_mid;
  always_comb begin
    if (cmd.rd_first) begin
      e_raddr = base;
    end else if (cmd.rd_last) begin
      e_raddr = base + EW'(n_cur);
    end else begin
      e_raddr = base + EW'(mid);
    end
  end
  assign e_waddr = (axis_in ? EW'(jhba_pkg::EDGE_ROW) : '0) + EW'(slot[BW-1:0]);
  assign e_we = cmd.ld_out && (mode == jhba_pkg::MODE_LOAD) &&
                (slot <= 13'(jhba_pkg::MAX_BINS));

  jhba_ram #(.WIDTH(VW), .DEPTH(jhba_pkg::EDGE_DEPTH)) u_edge (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(va),
    .re(e_re), .raddr(e_raddr), .rdata(e_rdata)
  );

  // binary search
  logic          lt_first, early;
  logic [BW-1:0] bin_early;
  logic [BW-1:0] ba, bb;
  assign early = lt_first || (v_cur >= e_val);
  always_comb begin
    if (lt_first) begin
      bin_early = '0;
    end else if (incmax_cur && (v_cur == e_val)) begin
      bin_early = n_cur;
    end else begin
      bin_early = n_cur + BW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.axis_first) begin
      axis <= 1'b0;
      bb <= '0;
    end else if (cmd.axis_next) begin
      axis <= 1'b1;
    end
    if (cmd.rd_first) begin
      lo <= '0;
      hi <= n_cur;
    end
    if (cmd.cap_first) begin
      lt_first <= (v_cur < e_val);
    end
    if (cmd.step) begin
      if (e_val <= v_cur) begin
        lo <= mid;
      end else begin
        hi <= mid;
      end
    end
    if ((cmd.chk && early) || cmd.fin_search) begin
      if (axis) begin
        bb <= cmd.chk ? bin_early : lo + BW'(1);
      end else begin
        ba <= cmd.chk ? bin_early : lo + BW'(1);
      end
    end
  end

  // flat index
  logic [AW-1:0] flat;
  logic [AW-1:0] prod;
  assign prod = AW'(ba) * AW'(nb + BW'(2));
  always_ff @(posedge clk) begin
    if (cmd.mk_flat) begin
      flat <= nax2 ? prod + AW'(bb) : AW'(ba);
    end
  end

  // count store with clearing pass
  logic [AW-1:0]        clr_cnt;
  logic [AW-1:0]        c_waddr, c_raddr;
  logic [CW-1:0]        c_rdata;
  logic [CW-1:0]        c_wdata;
  logic                 c_we, c_re, skip, rd_ok;
  logic signed [CW-1:0] c_val, add, sat;
  logic signed [CW:0]   sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt <= clr_cnt + AW'(1);
    end
  end

  assign skip = ma || (nax2 && mb) || (weighted && mw);
  assign c_val = c_rdata;
  assign add = weighted ? CW'(w) : jhba_pkg::ONE_Q16;
  assign sum = {c_val[CW-1], c_val} + {add[CW-1], add};
  always_comb begin
    if (sum[CW:CW-1] == 2'b01) begin
      sat = jhba_pkg::CNT_MAX;
    end else if (sum[CW:CW-1] == 2'b10) begin
      sat = jhba_pkg::CNT_MIN;
    end else begin
      sat = sum[CW-1:0];
    end
  end

  assign c_we = cmd.clr_step || (cmd.cnt_out && !skip);
  assign c_waddr = cmd.clr_step ? clr_cnt : flat;
  assign c_wdata = cmd.clr_step ? '0 : sat;
  assign c_re = cmd.cnt_rd || cmd.rd_rd;
  assign c_raddr = cmd.rd_rd ? slot : flat;
  assign rd_ok = (slot < 13'(jhba_pkg::STORE_DEPTH));

  jhba_ram #(.WIDTH(CW), .DEPTH(jhba_pkg::STORE_DEPTH)) u_count (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
    .re(c_re), .raddr(c_raddr), .rdata(c_rdata)
  );

  // result register
  logic out_load;
  assign out_load = cmd.cnt_out || cmd.rd_out || cmd.ld_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cnt_out) begin
      out_bin_a <= ba;
      out_bin_b <= bb;
      out_counted <= !skip;
      out_flat_index <= flat;
      out_count_value <= skip ? c_val : sat;
    end else if (cmd.rd_out) begin
      out_bin_a <= '0;
      out_bin_b <= '0;
      out_counted <= 1'b0;
      out_flat_index <= slot;
      out_count_value <= rd_ok ? c_val : '0;
    end else if (cmd.ld_out) begin
      out_bin_a <= '0;
      out_bin_b <= '0;
      out_counted <= 1'b0;
      out_flat_index <= '0;
      out_count_value <= '0;
    end
  end

  // status
  assign st.mode = mode;
  assign st.nax2 = nax2;
  assign st.axis = axis;
  assign st.early = early;
  assign st.narrow = (hi - lo) <= BW'(1);
  assign st.out_free = !out_valid || out_ready;
  assign st.clr_last = (clr_cnt == AW'(jhba_pkg::STORE_DEPTH - 1));

  // checks
  `JHBA_ASSERT(a_search_order, cmd.step |-> (lo < hi))
  `JHBA_ASSERT(a_flat_range, cmd.cnt_rd |-> (flat < AW'(jhba_pkg::STORE_DEPTH)))
  `JHBA_ASSERT(a_out_slot_free, out_load |-> (!out_valid || out_ready))
  `JHBA_ASSERT_RST(a_clear_in_range, cmd.clr_step |-> (clr_cnt < AW'(jhba_pkg::STORE_DEPTH)))

endmodule

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the joint histogram block: loads bin edges,
// pushes samples and count reads through the valid/ready channels under
// several idle/stall phases, and checks every result word against an
// internal predictor of edge search, flat index and saturating counts.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int BW = jhba_pkg::BIN_W;
  localparam int AW = jhba_pkg::CNT_AW;
  localparam int CW = jhba_pkg::CNT_W;

  typedef struct packed {
    logic [1:0]        mode;
    logic              axis;
    logic [12:0]       slot;
    logic signed [31:0] value_a;
    logic signed [31:0] value_b;
    logic              masked_a;
    logic              masked_b;
    logic signed [31:0] weight;
    logic              weight_masked;
  } sample_word_t;

  typedef struct packed {
    logic [BW-1:0]        bin_a;
    logic [BW-1:0]        bin_b;
    logic                 counted;
    logic [AW-1:0]        flat_index;
    logic signed [CW-1:0] count_value;
  } result_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [jhba_pkg::CFG_IW-1:0] cfg_index = '0;
  logic [jhba_pkg::CFG_DW-1:0] cfg_data = '0;

  jhba_in_if  samples();
  jhba_out_if results();

  joint_histogram_bin_accumulate dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .samples(samples.sink), .results(results.source)
  );

  always #5 clk = ~clk;

  // predictor state
  logic signed [31:0]  edges [jhba_pkg::EDGE_DEPTH];
  logic signed [CW-1:0] counts [jhba_pkg::STORE_DEPTH];
  int unsigned bins_a_q, bins_b_q, axes_q;
  bit incmax_a_q, incmax_b_q, weighted_q;

  sample_word_t pending_words [$];
  result_word_t expected_results [$];
  int unsigned accepted_words = 0, checked_results = 0, mismatches = 0;
  int unsigned samples_counted = 0;
  int unsigned send_idle_pct = 0, recv_stall_pct = 0;
  int unsigned hold_left = 0;

  function automatic int unsigned clamp_bins(int unsigned b);
    if (b < 1) return 1;
    if (b > jhba_pkg::MAX_BINS) return jhba_pkg::MAX_BINS;
    return b;
  endfunction

  // extended bin of v on one axis
  function automatic int unsigned find_bin(int unsigned ax, int unsigned n, bit incmax,
                                           logic signed [31:0] v);
    int unsigned lo, hi, mid, base;
    base = ax * jhba_pkg::EDGE_ROW;
    lo = 0;
    hi = n;
    if (v < edges[base]) return 0;
    if (v >= edges[base + n]) return (incmax && v == edges[base + n]) ? n : n + 1;
    while (hi - lo > 1) begin
      mid = (lo + hi) / 2;
      if (edges[base + mid] <= v) lo = mid; else hi = mid;
    end
    return lo + 1;
  endfunction

  // apply one word to the predictor, return its result
  function automatic result_word_t histogram_step(sample_word_t w);
    result_word_t r;
    int unsigned na, nb, nax, ba, bb, flat;
    bit skip;
    logic signed [CW+1:0] sum;
    r = '0;
    if (w.mode == jhba_pkg::MODE_LOAD) begin
      if (w.slot <= jhba_pkg::MAX_BINS)
        edges[w.axis * jhba_pkg::EDGE_ROW + w.slot] = w.value_a;
    end else if (w.mode == jhba_pkg::MODE_SAMPLE) begin
      na = clamp_bins(bins_a_q);
      nb = clamp_bins(bins_b_q);
      nax = (axes_q < 1) ? 1 : (axes_q > jhba_pkg::NUM_AXES ? jhba_pkg::NUM_AXES : axes_q);
      ba = find_bin(0, na, incmax_a_q, w.value_a);
      bb = 0;
      skip = w.masked_a;
      if (nax == 2) begin
        bb = find_bin(1, nb, incmax_b_q, w.value_b);
        flat = ba * (nb + 2) + bb;
        if (w.masked_b) skip = 1'b1;
      end else begin
        flat = ba;
      end
      if (weighted_q && w.weight_masked) skip = 1'b1;
      if (!skip) begin
        sum = counts[flat] + (weighted_q ? CW'(w.weight) : jhba_pkg::ONE_Q16);
        if (sum > jhba_pkg::CNT_MAX) sum = jhba_pkg::CNT_MAX;
        if (sum < jhba_pkg::CNT_MIN) sum = jhba_pkg::CNT_MIN;
        counts[flat] = sum[CW-1:0];
      end
      r.bin_a = BW'(ba);
      r.bin_b = BW'(bb);
      r.counted = !skip;
      r.flat_index = AW'(flat);
      r.count_value = counts[flat];
    end else if (w.mode == jhba_pkg::MODE_READ) begin
      r.flat_index = w.slot;
      if (w.slot < jhba_pkg::STORE_DEPTH) r.count_value = counts[w.slot];
    end
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      samples.valid <= 1'b0;
    end else if (!samples.valid || samples.ready) begin
      if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        sample_word_t w;
        w = pending_words.pop_front();
        samples.valid <= 1'b1;
        {samples.mode, samples.axis, samples.slot, samples.value_a, samples.value_b,
         samples.masked_a, samples.masked_b, samples.weight, samples.weight_masked} <= w;
        expected_results.push_back(histogram_step(w));
        accepted_words++;
      end else begin
        samples.valid <= 1'b0;
      end
    end
  end

  initial begin
    {samples.mode, samples.axis, samples.slot, samples.value_a, samples.value_b,
     samples.masked_a, samples.masked_b, samples.weight, samples.weight_masked} = '0;
    samples.valid = 1'b0;
    results.ready = 1'b0;
  end

  // long receiver hold, counted down one cycle at a time
  always @(posedge clk) begin
    if (hold_left > 0) hold_left <= hold_left - 1;
  end

  // receiver ready
  always @(posedge clk) begin
    if (rst) results.ready <= 1'b0;
    else results.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && results.valid && results.ready) begin
      result_word_t got, want;
      got = {results.bin_a, results.bin_b, results.counted, results.flat_index,
             results.count_value};
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", got);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: bin_a %0d/%0d bin_b %0d/%0d counted %0d/%0d idx %0d/%0d cnt %0d/%0d",
                     want.bin_a, got.bin_a, want.bin_b, got.bin_b, want.counted, got.counted,
                     want.flat_index, got.flat_index, want.count_value, got.count_value);
        end
        if (want.counted) samples_counted++;
      end
      checked_results++;
    end
  end

  task automatic write_reg(logic [jhba_pkg::CFG_IW-1:0] idx, int unsigned val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[jhba_pkg::CFG_DW-1:0];
    case (idx)
      jhba_pkg::CFG_BINS_A:   bins_a_q = val & 32'h7f;
      jhba_pkg::CFG_BINS_B:   bins_b_q = val & 32'h7f;
      jhba_pkg::CFG_INCMAX_A: incmax_a_q = val[0];
      jhba_pkg::CFG_INCMAX_B: incmax_b_q = val[0];
      jhba_pkg::CFG_WEIGHTED: weighted_q = val[0];
      jhba_pkg::CFG_AXES:     axes_q = val & 32'h3;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_words.size() > 0 || expected_results.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic set_config(int unsigned na, int unsigned nb, bit ia, bit ib, bit wt,
                            int unsigned nax);
    wait_drained();
    write_reg(jhba_pkg::CFG_BINS_A, na);
    write_reg(jhba_pkg::CFG_BINS_B, nb);
    write_reg(jhba_pkg::CFG_INCMAX_A, 32'(ia));
    write_reg(jhba_pkg::CFG_INCMAX_B, 32'(ib));
    write_reg(jhba_pkg::CFG_WEIGHTED, 32'(wt));
    write_reg(jhba_pkg::CFG_AXES, nax);
  endtask

  function automatic sample_word_t blank_word(logic [1:0] m);
    sample_word_t w;
    w = '0;
    w.mode = m;
    return w;
  endfunction

  // load all edges of both axes, sorted ascending with random spacing unless shuffled
  task automatic queue_edge_tables(bit shuffled);
    sample_word_t w;
    int signed v;
    for (int ax = 0; ax < jhba_pkg::NUM_AXES; ax++) begin
      v = -$signed($urandom_range(32'h0100_0000, 0));
      for (int k = 0; k <= jhba_pkg::MAX_BINS; k++) begin
        w = blank_word(jhba_pkg::MODE_LOAD);
        w.axis = 1'(ax);
        w.slot = 13'(k);
        w.value_a = shuffled ? $urandom() : v;
        pending_words.push_back(w);
        v = v + $urandom_range(32'h0008_0000, 1);
      end
    end
  endtask

  // random sample that often lands on or near edges
  function automatic sample_word_t random_sample();
    sample_word_t w;
    w = blank_word(jhba_pkg::MODE_SAMPLE);
    w.value_a = $urandom();
    w.value_b = $urandom();
    case ($urandom_range(3))
      0: w.value_a = edges[$urandom_range(jhba_pkg::MAX_BINS)];
      1: w.value_a = edges[$urandom_range(jhba_pkg::MAX_BINS)] + $urandom_range(3) - 1;
      2: w.value_a = edges[0] + $urandom_range(32'h0200_0000);
      default: ;
    endcase
    case ($urandom_range(3))
      0: w.value_b = edges[jhba_pkg::EDGE_ROW + $urandom_range(jhba_pkg::MAX_BINS)];
      1: w.value_b = edges[jhba_pkg::EDGE_ROW + $urandom_range(jhba_pkg::MAX_BINS)]
                     + $urandom_range(3) - 1;
      2: w.value_b = edges[jhba_pkg::EDGE_ROW] + $urandom_range(32'h0200_0000);
      default: ;
    endcase
    w.masked_a = ($urandom_range(9) == 0);
    w.masked_b = ($urandom_range(9) == 0);
    w.weight_masked = ($urandom_range(9) == 0);
    w.weight = ($urandom_range(3) == 0) ? $urandom() : $signed($urandom_range(32'h0003_0000))
               - 32'sh0001_0000;
    w.axis = 1'($urandom());
    w.slot = 13'($urandom());
    return w;
  endfunction

  function automatic sample_word_t random_word();
    sample_word_t w;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 75) return random_sample();
    w = random_sample();
    if (pick < 90) begin
      w.mode = jhba_pkg::MODE_READ;
      w.slot = ($urandom_range(7) == 0) ? 13'($urandom())
                                        : 13'($urandom_range(jhba_pkg::STORE_DEPTH - 1));
    end else if (pick < 96) begin
      // edge loads with slots past the table are ignored
      w.mode = jhba_pkg::MODE_LOAD;
      w.slot = 13'($urandom_range(8191, jhba_pkg::MAX_BINS + 1));
    end else begin
      w.mode = jhba_pkg::MODE_UNUSED;
    end
    return w;
  endfunction

  // apply a phase: config, then a batch of random words
  task automatic run_phase(int unsigned na, int unsigned nb, bit ia, bit ib, bit wt,
                           int unsigned nax, int unsigned n_words);
    set_config(na, nb, ia, ib, wt, nax);
    case ($urandom_range(3))
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
      default: begin send_idle_pct = 35; recv_stall_pct = 35; end
    endcase
    repeat (n_words) pending_words.push_back(random_word());
  endtask

  initial begin
    sample_word_t w;
    for (int i = 0; i < jhba_pkg::STORE_DEPTH; i++) counts[i] = '0;
    for (int i = 0; i < jhba_pkg::EDGE_DEPTH; i++) edges[i] = '0;
    bins_a_q = 1; bins_b_q = 1; incmax_a_q = 0; incmax_b_q = 0;
    weighted_q = 0; axes_q = 1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // edges first; mirror them in the predictor's view used by the stimulus
    queue_edge_tables(1'b0);
    wait_drained();

    // directed: extremes, masks, reads, unused mode, large weights
    set_config(64, 64, 1'b1, 1'b1, 1'b0, 2);
    w = blank_word(jhba_pkg::MODE_SAMPLE);
    w.value_a = 32'sh8000_0000; w.value_b = 32'sh7fff_ffff;
    pending_words.push_back(w);
    w.value_a = edges[jhba_pkg::MAX_BINS];
    w.value_b = edges[jhba_pkg::EDGE_ROW + jhba_pkg::MAX_BINS];
    pending_words.push_back(w);
    w.value_a = edges[0]; w.value_b = edges[jhba_pkg::EDGE_ROW]; w.masked_a = 1'b1;
    pending_words.push_back(w);
    w.masked_a = 1'b0; w.masked_b = 1'b1;
    pending_words.push_back(w);
    w = blank_word(jhba_pkg::MODE_READ);
    w.slot = 13'(jhba_pkg::STORE_DEPTH - 1);
    pending_words.push_back(w);
    w.slot = 13'h1fff; pending_words.push_back(w);
    w = blank_word(jhba_pkg::MODE_UNUSED); w.slot = 13'h1fff; w.value_a = '1;
    pending_words.push_back(w);
    set_config(64, 64, 1'b0, 1'b0, 1'b0, 2);
    w = blank_word(jhba_pkg::MODE_SAMPLE);
    w.value_a = edges[jhba_pkg::MAX_BINS];
    w.value_b = edges[jhba_pkg::EDGE_ROW + jhba_pkg::MAX_BINS];
    pending_words.push_back(w);
    // weighted: add the largest positive, then the most negative weights to one cell
    set_config(0, 127, 1'b0, 1'b0, 1'b1, 0);
    w = blank_word(jhba_pkg::MODE_SAMPLE);
    w.value_a = 32'sh7fff_ffff;
    w.weight = 32'sh7fff_ffff;
    repeat (4) pending_words.push_back(w);
    w.weight_masked = 1'b1; pending_words.push_back(w);
    w.weight_masked = 1'b0; w.weight = 32'sh8000_0000;
    repeat (3) pending_words.push_back(w);
    set_config(1, 1, 1'b1, 1'b0, 1'b1, 3);
    w.masked_b = 1'b1; w.weight = '1; pending_words.push_back(w);

    // random phases across the settings space
    for (int p = 0; p < 14; p++)
      run_phase($urandom_range(64), $urandom_range(64), 1'($urandom()), 1'($urandom()),
                1'($urandom()), $urandom_range(3), 110);
    set_config(64, 64, 1'b1, 1'b1, 1'b1, 2);

    // long receiver hold while the sender keeps offering
    send_idle_pct = 0;
    hold_left = 400;
    repeat (20) pending_words.push_back(random_word());
    wait (hold_left == 0);
    wait_drained();

    // unordered edges, then more random traffic
    queue_edge_tables(1'b1);
    for (int p = 0; p < 2; p++)
      run_phase($urandom_range(64, 1), $urandom_range(64, 1), 1'($urandom()),
                1'($urandom()), 1'($urandom()), $urandom_range(2, 1), 90);

    wait_drained();
    $display("covered %0d words, %0d results checked, %0d samples counted",
             accepted_words, checked_results, samples_counted);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("FAIL");
    $finish;
  end
endmodule
